// File: hw/rtl/angular_accel_limit_interpolator_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the angular acceleration limit interpolator
// Property wrappers sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ANGULAR_ACCEL_LIMIT_INTERPOLATOR_TOP_DEFINES_SVH
`define ANGULAR_ACCEL_LIMIT_INTERPOLATOR_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define AALI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define AALI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/aali_pkg.sv
// ----------------------------------------------------------------------------
// aali_pkg
// Shared types, constants and tables of the acceleration limit interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aali_pkg;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int ANGLE_BITS      = 16;
	localparam int CORDIC_ITERS    = 16;
	localparam int STEP_W          = $clog2(CORDIC_ITERS);

	localparam logic [15:0] FALLBACK_LINEAR  = 16'd512;
	localparam logic [15:0] FALLBACK_ANGULAR = 16'd2560;
	localparam logic [15:0] CORDIC_KINV      = 16'd39797;

	// action codes
	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_QUERY  = 2'd1;
	localparam logic [1:0] ACT_CHECK  = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic               first_entry;
		logic [15:0]        entry_angle;
		logic [15:0]        entry_limit;
		logic [15:0]        direction;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_angular;
	} aali_in_t;

	typedef struct packed {
		logic [15:0]        linear_limit;
		logic [15:0]        angular_limit;
		logic signed [15:0] limit_x;
		logic signed [15:0] limit_y;
		logic               feasible;
	} aali_out_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic append;
		logic fallback;
		logic dir_from_item;
		logic scan_init;
		logic scan;
		logic fetch_lo;
		logic fetch_hi;
		logic take_lo;
		logic take_hi;
		logic prep;
		logic mul1;
		logic mul2;
		logic div_load;
		logic div_step;
		logic interp_fin;
		logic rot_init;
		logic vec_init;
		logic cordic_step;
		logic rot_fin;
		logic vec_fin;
		logic compare;
		logic load_res;
	} aali_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic scan_done;
		logic step_last;
	} aali_status_t;

	// arctangent of 2^-i as a 32-bit binary angle
	function automatic logic [31:0] atan_at(input logic [STEP_W-1:0] i);
		logic [31:0] r;
		case (i)
			4'd0:    r = 32'h2000_0000;
			4'd1:    r = 32'h12E4_051E;
			4'd2:    r = 32'h09FB_385B;
			4'd3:    r = 32'h0511_11D4;
			4'd4:    r = 32'h028B_0D43;
			4'd5:    r = 32'h0145_D7E1;
			4'd6:    r = 32'h00A2_F61E;
			4'd7:    r = 32'h0051_7C55;
			4'd8:    r = 32'h0028_BE53;
			4'd9:    r = 32'h0014_5F2F;
			4'd10:   r = 32'h000A_2F98;
			4'd11:   r = 32'h0005_17CC;
			4'd12:   r = 32'h0002_8BE6;
			4'd13:   r = 32'h0001_45F3;
			4'd14:   r = 32'h0000_A2FA;
			default: r = 32'h0000_517D;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/angular_accel_limit_interpolator_top.sv
// Items are taken one at a time, paced by the scan (one entry per cycle on the memory read
// port), the 16-step divider and the 16-step CORDIC unit.
// Reset: entry count cleared, angular setting back to 10.0; table contents undefined.
// ----------------------------------------------------------------------------
// angular_accel_limit_interpolator_top
// Angle-indexed acceleration limit table with interpolation and envelope check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module angular_accel_limit_interpolator_top #(
	parameter int TABLE_DEPTH = aali_pkg::DEF_TABLE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire aali_pkg::aali_in_t  item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output aali_pkg::aali_out_t      result,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [15:0]         cfg_data
);
	import aali_pkg::*;

	aali_cmd_t    cmd;
	aali_status_t status;

	// the setting register takes a beat in any cycle
	assign cfg_ready = 1'b1;

	aali_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_action  (item.action),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.status       (status)
	);

	aali_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.result   (result)
	);

endmodule

`default_nettype wire

// File: hw/rtl/aali_ctrl.sv
// ----------------------------------------------------------------------------
// aali_ctrl
// Sequencer: walks one item through scan, interpolation, CORDIC and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aali_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire logic [1:0]            item_action,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output aali_pkg::aali_cmd_t        cmd,
	input  wire aali_pkg::aali_status_t status
);
	import aali_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_SCAN, S_FETCH_LO, S_FETCH_HI, S_TAKE_HI, S_PREP, S_MUL1, S_MUL2,
		S_DIV_LOAD, S_DIV, S_INTERP_FIN, S_ROT_INIT, S_VEC_INIT, S_CORDIC,
		S_ROT_FIN, S_VEC_FIN, S_COMPARE, S_RESULT
	} state_t;

	state_t state_q, state_d;
	logic   check_q, check_d;
	logic   out_valid_q;
	logic   accept;
	logic   res_free;

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = out_valid_q;
	assign res_free     = !out_valid_q || result_ready;

	// decode state into datapath commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		check_d = check_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item_action)
						ACT_APPEND: begin
							cmd.append = 1'b1;
						end
						ACT_QUERY: begin
							cmd.start         = 1'b1;
							cmd.dir_from_item = 1'b1;
							check_d           = 1'b0;
							if (status.empty) begin
								cmd.fallback = 1'b1;
								state_d      = S_ROT_INIT;
							end else begin
								cmd.scan_init     = 1'b1;
								state_d           = S_SCAN;
							end
						end
						ACT_CHECK: begin
							cmd.start = 1'b1;
							check_d   = 1'b1;
							if (status.empty) begin
								cmd.fallback = 1'b1;
								state_d      = S_RESULT;
							end else begin
								state_d = S_VEC_INIT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) begin
					state_d = S_FETCH_LO;
				end
			end
			S_FETCH_LO: begin
				cmd.fetch_lo = 1'b1;
				state_d      = S_FETCH_HI;
			end
			S_FETCH_HI: begin
				cmd.fetch_hi = 1'b1;
				cmd.take_lo  = 1'b1;
				state_d      = S_TAKE_HI;
			end
			S_TAKE_HI: begin
				cmd.take_hi = 1'b1;
				state_d     = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_DIV_LOAD;
			end
			S_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.step_last) begin
					state_d = S_INTERP_FIN;
				end
			end
			S_INTERP_FIN: begin
				cmd.interp_fin = 1'b1;
				state_d        = check_q ? S_COMPARE : S_ROT_INIT;
			end
			S_ROT_INIT: begin
				cmd.rot_init = 1'b1;
				state_d      = S_CORDIC;
			end
			S_VEC_INIT: begin
				cmd.vec_init = 1'b1;
				state_d      = S_CORDIC;
			end
			S_CORDIC: begin
				cmd.cordic_step = 1'b1;
				if (status.step_last) begin
					state_d = check_q ? S_VEC_FIN : S_ROT_FIN;
				end
			end
			S_ROT_FIN: begin
				cmd.rot_fin = 1'b1;
				state_d     = S_RESULT;
			end
			S_VEC_FIN: begin
				cmd.vec_fin   = 1'b1;
				cmd.scan_init = 1'b1;
				state_d       = S_SCAN;
			end
			S_COMPARE: begin
				cmd.compare = 1'b1;
				state_d     = S_RESULT;
			end
			S_RESULT: begin
				if (res_free) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// hold state, mode and the output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			check_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			check_q <= check_d;
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/aali_dp.sv
// ----------------------------------------------------------------------------
// aali_dp
// Datapath: entry memory, scan, interpolation divider, shared CORDIC unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aali_dp #(
	parameter int TABLE_DEPTH = aali_pkg::DEF_TABLE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire aali_pkg::aali_in_t  item,
	input  wire logic                cfg_we,
	input  wire logic [15:0]         cfg_data,
	input  wire aali_pkg::aali_cmd_t cmd,
	output aali_pkg::aali_status_t   status,
	output aali_pkg::aali_out_t      result
);
	import aali_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic signed [33:0] Z_QUARTER = 34'sh0_4000_0000;
	localparam logic signed [33:0] Z_HALF    = 34'sh0_8000_0000;

	// entry memory, {angle, limit}
	logic [31:0]         mem [TABLE_DEPTH];
	logic [31:0]         rd_q;
	logic [AW-1:0]       rd_addr;

	logic [CW-1:0]       cnt_q;
	logic [15:0]         setting_q;
	aali_in_t            item_q;
	logic [15:0]         dir_q;

	logic [CW-1:0]       scan_i_q;
	logic                pend_q;
	logic [AW-1:0]       pend_i_q;
	logic [AW-1:0]       idx_q;
	logic [15:0]         a1_q, l1_q, a2_q, l2_q;
	logic [16:0]         span_q, d_q;
	logic [32:0]         acc_q;
	logic [16:0]         rem_q;
	logic [15:0]         quo_q;
	logic [STEP_W-1:0]   step_q;

	logic signed [35:0]  cx_q, cy_q;
	logic signed [33:0]  cz_q;
	logic                vec_q;
	logic [49:0]         mag_q;

	logic [15:0]         lin_q, ang_q;
	logic signed [15:0]  limx_q, limy_q;
	logic                feas_q;
	aali_out_t           res_q;

	// append address and fit
	logic [CW-1:0]       wr_base;
	logic                wr_ok;
	// scan and neighbor index
	logic                issue_ok;
	logic                hit_stop;
	logic [CW-1:0]       cnt_m1;
	logic [CW-1:0]       idx_ext;
	logic [AW-1:0]       nxt;
	// interval setup
	logic [16:0]         a2x, degx, span_c, dd_c;
	// divider step
	logic [17:0]         div_t;
	logic                div_ge;
	logic [17:0]         div_sub;
	// cordic
	logic [31:0]         rot_prod;
	logic signed [35:0]  rot_x;
	logic signed [33:0]  rot_z;
	logic signed [35:0]  vx0, vy0;
	logic signed [35:0]  sh_x, sh_y;
	logic signed [33:0]  at;
	logic                neg;
	logic signed [35:0]  fx, fy;
	logic [31:0]         zr;
	logic [16:0]         aabs;

	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		logic signed [15:0] r;
		if (v > 36'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -36'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	assign wr_base  = item.first_entry ? '0 : cnt_q;
	assign wr_ok    = wr_base < CW'(TABLE_DEPTH);
	assign issue_ok = scan_i_q < cnt_q;
	assign hit_stop = pend_q && (rd_q[31:16] > dir_q);
	assign cnt_m1   = cnt_q - CW'(1);
	assign idx_ext  = CW'(idx_q) + CW'(1);
	assign nxt      = (idx_ext < cnt_q) ? idx_ext[AW-1:0] : '0;

	assign status.empty     = (cnt_q == '0);
	assign status.scan_done = hit_stop || (!pend_q && !issue_ok);
	assign status.step_last = (step_q == STEP_W'(CORDIC_ITERS - 1));

	// select the memory read address
	always_comb begin
		if (cmd.fetch_lo) begin
			rd_addr = idx_q;
		end else if (cmd.fetch_hi) begin
			rd_addr = nxt;
		end else begin
			rd_addr = scan_i_q[AW-1:0];
		end
	end

	// unwrap the interval across zero; prep clamps the distance to the span
	always_comb begin
		a2x    = (a2_q < a1_q) ? {1'b1, a2_q} : {1'b0, a2_q};
		degx   = (dir_q < a1_q) ? {1'b1, dir_q} : {1'b0, dir_q};
		span_c = a2x - {1'b0, a1_q};
		dd_c   = degx - {1'b0, a1_q};
	end

	// restoring divide, one quotient bit per step
	always_comb begin
		div_t   = {rem_q, quo_q[15]};
		div_ge  = div_t >= {1'b0, span_q};
		div_sub = div_t - {1'b0, span_q};
	end

	// cordic setup, one micro-rotation, output rounding and the angular magnitude
	always_comb begin
		rot_prod = 32'(lin_q) * 32'(CORDIC_KINV);
		rot_x    = $signed(36'(rot_prod));
		rot_z    = {{2{dir_q[15]}}, dir_q, 16'h0000};
		vx0      = {{4{item_q.accel_x[15]}}, item_q.accel_x, 16'h0000};
		vy0      = {{4{item_q.accel_y[15]}}, item_q.accel_y, 16'h0000};
		sh_x     = cx_q >>> step_q;
		sh_y     = cy_q >>> step_q;
		at       = $signed({2'b00, atan_at(step_q)});
		neg      = vec_q ? !cy_q[35] : cz_q[33];
		fx       = (cx_q + 36'sd32768) >>> 16;
		fy       = (cy_q + 36'sd32768) >>> 16;
		zr       = cz_q[31:0] + 32'h0000_8000;
		aabs     = item_q.accel_angular[15] ?
			17'(-$signed({item_q.accel_angular[15], item_q.accel_angular})) :
			{1'b0, item_q.accel_angular};
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.append && wr_ok) begin
			mem[wr_base[AW-1:0]] <= {item.entry_angle, item.entry_limit};
		end
		rd_q <= mem[rd_addr];
	end

	// control state: count and setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			setting_q <= FALLBACK_ANGULAR;
		end else begin
			if (cfg_we) begin
				setting_q <= cfg_data;
			end
			if (cmd.append && wr_ok) begin
				cnt_q <= wr_base + CW'(1);
			end else if (cmd.append) begin
				cnt_q <= wr_base;
			end
		end
	end

	// scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_i_q <= '0;
			pend_q   <= 1'b0;
			pend_i_q <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.scan_init) begin
				scan_i_q <= '0;
				pend_q   <= 1'b0;
				idx_q    <= cnt_m1[AW-1:0];
			end else if (cmd.scan) begin
				pend_q   <= issue_ok;
				pend_i_q <= scan_i_q[AW-1:0];
				if (issue_ok) begin
					scan_i_q <= scan_i_q + CW'(1);
				end
				if (pend_q && !hit_stop) begin
					idx_q <= pend_i_q;
				end
			end
		end
	end

	// interpolation, cordic and result working registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			item_q <= item;
			feas_q <= 1'b0;
			limx_q <= '0;
			limy_q <= '0;
			ang_q  <= cmd.fallback ? FALLBACK_ANGULAR : setting_q;
		end
		if (cmd.fallback) begin
			lin_q <= FALLBACK_LINEAR;
		end
		if (cmd.dir_from_item) begin
			dir_q <= item.direction;
		end
		if (cmd.take_lo) begin
			a1_q <= rd_q[31:16];
			l1_q <= rd_q[15:0];
		end
		if (cmd.take_hi) begin
			a2_q <= rd_q[31:16];
			l2_q <= rd_q[15:0];
		end
		if (cmd.prep) begin
			span_q <= span_c;
			d_q    <= (dd_c > span_c) ? span_c : dd_c;
		end
		if (cmd.mul1) begin
			acc_q <= 33'(l1_q) * 33'(span_q - d_q);
		end
		if (cmd.mul2) begin
			acc_q <= acc_q + 33'(l2_q) * 33'(d_q) + 33'(span_q >> 1);
		end
		if (cmd.div_load) begin
			rem_q <= acc_q[32:16];
			quo_q <= acc_q[15:0];
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? div_sub[16:0] : div_t[16:0];
			quo_q <= {quo_q[14:0], div_ge};
		end
		if (cmd.interp_fin) begin
			lin_q <= (span_q == '0) ? l1_q : quo_q;
		end
		// fold the angle into the right half plane before rotating
		if (cmd.rot_init) begin
			vec_q <= 1'b0;
			cy_q  <= '0;
			if (rot_z > Z_QUARTER) begin
				cz_q <= rot_z - Z_HALF;
				cx_q <= -rot_x;
			end else if (rot_z < -Z_QUARTER) begin
				cz_q <= rot_z + Z_HALF;
				cx_q <= -rot_x;
			end else begin
				cz_q <= rot_z;
				cx_q <= rot_x;
			end
		end
		if (cmd.vec_init) begin
			vec_q <= 1'b1;
			if (vx0 < 0) begin
				cx_q <= -vx0;
				cy_q <= -vy0;
				cz_q <= Z_HALF;
			end else begin
				cx_q <= vx0;
				cy_q <= vy0;
				cz_q <= '0;
			end
		end
		if (cmd.cordic_step) begin
			if (!neg) begin
				cx_q <= cx_q - sh_y;
				cy_q <= cy_q + sh_x;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + sh_y;
				cy_q <= cy_q - sh_x;
				cz_q <= cz_q + at;
			end
		end
		if (cmd.rot_fin) begin
			limx_q <= sat16(fx);
			limy_q <= sat16(fy);
		end
		if (cmd.vec_fin) begin
			dir_q <= zr[31:16];
			mag_q <= 50'(cx_q[33:0]) * 50'(CORDIC_KINV);
		end
		if (cmd.compare) begin
			feas_q <= (mag_q <= 50'({lin_q, 32'h0000_0000})) && (aabs <= {1'b0, ang_q});
		end
		if (cmd.load_res) begin
			res_q <= '{linear_limit: lin_q, angular_limit: ang_q, limit_x: limx_q,
				limit_y: limy_q, feasible: feas_q};
		end
	end

	// step counter shared by divider and cordic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_load || cmd.rot_init || cmd.vec_init) begin
			step_q <= '0;
		end else if (cmd.div_step || cmd.cordic_step) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

// File: hw/rtl/aali_checker.sv
// ----------------------------------------------------------------------------
// aali_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "angular_accel_limit_interpolator_top_defines.svh"

module aali_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                item_valid,
	input wire logic                item_ready,
	input wire logic                result_valid,
	input wire logic                result_ready,
	input wire aali_pkg::aali_out_t result
);
	import aali_pkg::*;

	// a stalled result beat holds
	`AALI_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")

	// only a check can pass, and a check reports no components
	`AALI_ASSERT_SAME(a_feas_no_xy, result_valid && result.feasible, result.limit_x == 16'sd0 && result.limit_y == 16'sd0, "feasible result with nonzero components")

	// a result appears only while the input side is busy
	`AALI_ASSERT_SAME(a_res_after_busy, $rose(result_valid), !$past(item_ready), "result appeared while idle")

endmodule

bind angular_accel_limit_interpolator_top aali_checker u_chk (.*);

`default_nettype wire
